// ===== src/cgi_pkg.sv =====
package cgi_pkg;

  // Run length limit and field widths.
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CountW    = 7;
  localparam int unsigned PixW      = 24;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;

  // Internal widths: end distance D, D squared, partial sums, numerator, remainder.
  localparam int unsigned DW        = $clog2(MaxPoints);
  localparam int unsigned DsqW      = 2 * DW;
  localparam int unsigned AW        = 17;
  localparam int unsigned NumW      = 23;
  localparam int unsigned RemW      = 20;
  localparam int unsigned DivStages = ChanW / 2;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef logic [ChanW-1:0]        chan_t;
  typedef logic signed [ChanW:0]   delta_t;
  typedef logic signed [AW-1:0]    part_t;
  typedef logic signed [NumW-1:0]  num_t;
  typedef logic [RemW-1:0]         rem_t;
  typedef logic [DsqW-1:0]         dsq_t;
  typedef logic [DW-1:0]           pos_t;

  // Channel c of a packed BGR pixel.
  function automatic chan_t chan_of(input logic [PixW-1:0] px, input int unsigned c);
    return px[c*ChanW +: ChanW];
  endfunction

endpackage

// ===== src/cgi_if.sv =====
interface cgi_req_if;
  logic                          valid;
  logic                          ready;
  logic                          four_point;
  logic [cgi_pkg::CountW-1:0]    count;
  logic [cgi_pkg::PixW-1:0]      pixel_a;
  logic [cgi_pkg::PixW-1:0]      pixel_b;
  logic [cgi_pkg::PixW-1:0]      pixel_c;
  logic [cgi_pkg::PixW-1:0]      pixel_d;

  modport source (output valid, four_point, count, pixel_a, pixel_b, pixel_c, pixel_d,
                  input ready);
  modport sink   (input valid, four_point, count, pixel_a, pixel_b, pixel_c, pixel_d,
                  output ready);
endinterface

interface cgi_pix_if;
  logic                          valid;
  logic                          ready;
  logic [cgi_pkg::ChanW-1:0]     blue;
  logic [cgi_pkg::ChanW-1:0]     green;
  logic [cgi_pkg::ChanW-1:0]     red;
  logic                          last;

  modport source (output valid, blue, green, red, last, input ready);
  modport sink   (input valid, blue, green, red, last, output ready);
endinterface

// ===== src/color_gradient_interpolator_core.sv =====
// A request transfer loads the sequencer; each pixel then passes stage 1, stage 2,
// the clamp register, the divider stages and the output register. Throughput: one
// pixel per cycle unless the output stalls; no request is taken while a run is walked.
// The divide by D squared is a restoring divider of two quotient bits per stage.
// Reset (asynchronous, active low) clears the run-active flag and all valid bits.
module color_gradient_interpolator_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  cgi_req_if.sink  req_i,
  cgi_pix_if.source pix_o
);
  import cgi_pkg::*;

  // Global advance: the whole pipeline moves when the output register can take data.
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || pix_o.ready;

  // Run sequencer registers.
  logic   active_q;
  pos_t   d_q, j_q;
  chan_t  lv_q [NumChan];
  chan_t  rv_q [NumChan];
  delta_t dl_q [NumChan];
  delta_t dr_q [NumChan];

  logic                accept;
  logic [CountW-1:0]   n_sat;
  assign req_i.ready = !active_q;
  assign accept      = req_i.valid && !active_q;
  assign n_sat = (req_i.count > CountW'(MaxPoints)) ? CountW'(MaxPoints) : req_i.count;

  // Latch the end colors and slopes of a request and walk its positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (accept) begin
      active_q <= (n_sat != '0);
    end else if (active_q && en && (j_q == d_q)) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_q <= DW'(n_sat - CountW'(1));
      j_q <= '0;
      for (int c = 0; c < NumChan; c++) begin
        if (req_i.four_point) begin
          lv_q[c] <= chan_of(req_i.pixel_b, c);
          rv_q[c] <= chan_of(req_i.pixel_c, c);
          dl_q[c] <= $signed({1'b0, chan_of(req_i.pixel_b, c)})
                   - $signed({1'b0, chan_of(req_i.pixel_a, c)});
          dr_q[c] <= $signed({1'b0, chan_of(req_i.pixel_c, c)})
                   - $signed({1'b0, chan_of(req_i.pixel_d, c)});
        end else begin
          lv_q[c] <= chan_of(req_i.pixel_a, c);
          rv_q[c] <= chan_of(req_i.pixel_b, c);
          dl_q[c] <= '0;
          dr_q[c] <= '0;
        end
      end
    end else if (active_q && en) begin
      j_q <= j_q + DW'(1);
    end
  end

  // Stage 1: end terms L*D + dl*j and R*D + dr*(D-j).
  logic  v1_q;
  part_t a1_q [NumChan];
  part_t b1_q [NumChan];
  pos_t  dj1_q, j1_q;
  dsq_t  dsq1_q;
  logic  last1_q;

  pos_t  dm;
  part_t a_d [NumChan];
  part_t b_d [NumChan];
  assign dm = d_q - j_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (d_q == '0) begin
        a_d[c] = AW'($signed({1'b0, lv_q[c]}));
        b_d[c] = '0;
      end else begin
        a_d[c] = AW'($signed({1'b0, lv_q[c]})) * AW'($signed({1'b0, d_q}))
               + AW'(dl_q[c]) * AW'($signed({1'b0, j_q}));
        b_d[c] = AW'($signed({1'b0, rv_q[c]})) * AW'($signed({1'b0, d_q}))
               + AW'(dr_q[c]) * AW'($signed({1'b0, dm}));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= a_d;
      b1_q    <= b_d;
      dj1_q   <= (d_q == '0) ? DW'(1) : dm;
      j1_q    <= j_q;
      dsq1_q  <= (d_q == '0) ? DsqW'(1) : DsqW'(d_q * d_q);
      last1_q <= (j_q == d_q);
    end
  end

  // Stage 2: numerator a*(D-j) + b*j.
  logic v2_q;
  num_t num2_q [NumChan];
  dsq_t dsq2_q;
  logic last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumChan; c++) begin
        num2_q[c] <= NumW'(a1_q[c]) * NumW'($signed({1'b0, dj1_q}))
                   + NumW'(b1_q[c]) * NumW'($signed({1'b0, j1_q}));
      end
      dsq2_q  <= dsq1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3 and divider stages. Index 0 holds the clamp decision; index s+1 the
  // result of divider stage s. A clamped value enters with a zero remainder.
  logic  vs_q    [DivStages+1];
  rem_t  rs_q    [DivStages+1][NumChan];
  chan_t qs_q    [DivStages+1][NumChan];
  dsq_t  dsqs_q  [DivStages+1];
  logic  lasts_q [DivStages+1];

  rem_t  rs_d [DivStages+1][NumChan];
  chan_t qs_d [DivStages+1][NumChan];

  always_comb begin
    rem_t t;
    rem_t r;
    chan_t q;
    for (int c = 0; c < NumChan; c++) begin
      if (num2_q[c] < 0) begin
        rs_d[0][c] = '0;
        qs_d[0][c] = '0;
      end else if (num2_q[c][NumW-2:0] >= (NumW-1)'({dsq2_q, 8'b0})) begin
        rs_d[0][c] = '0;
        qs_d[0][c] = ChanMax;
      end else begin
        rs_d[0][c] = num2_q[c][RemW-1:0];
        qs_d[0][c] = '0;
      end
    end
    for (int s = 0; s < DivStages; s++) begin
      for (int c = 0; c < NumChan; c++) begin
        r = rs_q[s][c];
        q = qs_q[s][c];
        for (int k = 0; k < 2; k++) begin
          t = RemW'(dsqs_q[s]) << (ChanW - 1 - 2 * s - k);
          if (r >= t) begin
            r = r - t;
            q[ChanW - 1 - 2 * s - k] = 1'b1;
          end
        end
        rs_d[s+1][c] = r;
        qs_d[s+1][c] = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DivStages; s++) vs_q[s] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= v2_q;
      for (int s = 1; s <= DivStages; s++) vs_q[s] <= vs_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q       <= rs_d;
      qs_q       <= qs_d;
      dsqs_q[0]  <= dsq2_q;
      lasts_q[0] <= last2_q;
      for (int s = 1; s <= DivStages; s++) begin
        dsqs_q[s]  <= dsqs_q[s-1];
        lasts_q[s] <= lasts_q[s-1];
      end
    end
  end

  // Output register: holds a finished pixel until its transfer.
  chan_t out_q [NumChan];
  logic  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vs_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= qs_q[DivStages];
      out_last_q <= lasts_q[DivStages];
    end
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.blue  = out_q[0];
  assign pix_o.green = out_q[1];
  assign pix_o.red   = out_q[2];
  assign pix_o.last  = out_last_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cgi_pkg::*;

  localparam int unsigned NumRandom  = 120;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic                  four_point;
    logic [CountW-1:0]     count;
    logic [PixW-1:0]       pixel_a;
    logic [PixW-1:0]       pixel_b;
    logic [PixW-1:0]       pixel_c;
    logic [PixW-1:0]       pixel_d;
  } request_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    logic  last;
  } pixel_t;

  // Gradient predictor and store of pixels still owed by the block.
  class gradient_board;
    pixel_t owed_pixels[$];

    function longint unsigned channel_value(longint lv, longint rv, longint dl,
                                            longint dr, longint d, longint j);
      longint num;
      longint q;
      if (d == 0) return lv;
      num = (lv * d + dl * j) * (d - j) + (rv * d + dr * (d - j)) * j;
      if (num < 0) return 0;
      q = num / (d * d);
      if (q > 255) q = 255;
      return q;
    endfunction

    // Works out every pixel of the run that an accepted request causes.
    function void note_request(request_t rq);
      int unsigned n;
      longint lv[NumChan], rv[NumChan], dl[NumChan], dr[NumChan];
      chan_t vals[NumChan];
      pixel_t px;
      n = (rq.count > MaxPoints) ? MaxPoints : rq.count;
      for (int c = 0; c < NumChan; c++) begin
        if (rq.four_point) begin
          lv[c] = longint'(rq.pixel_b[c*ChanW +: ChanW]);
          rv[c] = longint'(rq.pixel_c[c*ChanW +: ChanW]);
          dl[c] = lv[c] - longint'(rq.pixel_a[c*ChanW +: ChanW]);
          dr[c] = rv[c] - longint'(rq.pixel_d[c*ChanW +: ChanW]);
        end else begin
          lv[c] = longint'(rq.pixel_a[c*ChanW +: ChanW]);
          rv[c] = longint'(rq.pixel_b[c*ChanW +: ChanW]);
          dl[c] = 0;
          dr[c] = 0;
        end
      end
      for (int j = 0; j < n; j++) begin
        for (int c = 0; c < NumChan; c++) begin
          vals[c] = chan_t'(channel_value(lv[c], rv[c], dl[c], dr[c], n - 1, j));
        end
        px.blue  = vals[0];
        px.green = vals[1];
        px.red   = vals[2];
        px.last  = (j == n - 1);
        owed_pixels.push_back(px);
      end
    endfunction

    // Compares one output pixel with the oldest owed one; empty string on a match.
    function string check_pixel(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) return $sformatf("unexpected pixel %p", got);
      want = owed_pixels.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
          got.last !== want.last) begin
        return $sformatf("pixel mismatch: got %p, want %p", got, want);
      end
      return "";
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit sending_done = 1'b0;
  gradient_board board = new();

  cgi_req_if req();
  cgi_pix_if pix();

  color_gradient_interpolator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pix_o  (pix)
  );

  always #4 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    rq.four_point = 1'($urandom_range(0, 1));
    if (sel < 14) rq.count = CountW'($urandom_range(0, 8));
    else if (sel < 19) rq.count = CountW'($urandom_range(9, 64));
    else rq.count = CountW'($urandom_range(65, 127));
    rq.pixel_a = pick_pixel();
    rq.pixel_b = pick_pixel();
    rq.pixel_c = pick_pixel();
    rq.pixel_d = pick_pixel();
    return rq;
  endfunction

  // Offers one request from a falling edge and waits for its transfer.
  task automatic send_request(request_t rq, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.four_point = rq.four_point;
    req.count      = rq.count;
    req.pixel_a    = rq.pixel_a;
    req.pixel_b    = rq.pixel_b;
    req.pixel_c    = rq.pixel_c;
    req.pixel_d    = rq.pixel_d;
    req.valid      = 1'b1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    board.note_request(rq);
  endtask

  function automatic request_t make_request(logic fp, logic [CountW-1:0] n,
                                            logic [PixW-1:0] a, logic [PixW-1:0] b,
                                            logic [PixW-1:0] c, logic [PixW-1:0] d);
    request_t rq;
    rq = '{four_point: fp, count: n, pixel_a: a, pixel_b: b, pixel_c: c, pixel_d: d};
    return rq;
  endfunction

  // Request stream: directed corners first, then random runs.
  initial begin
    request_t directed[$];
    req.valid = 1'b0;
    req.four_point = 1'b0;
    req.count = '0;
    req.pixel_a = '0;
    req.pixel_b = '0;
    req.pixel_c = '0;
    req.pixel_d = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    // Zero count, single pixel, saturated counts, and both clamp directions.
    directed.push_back(make_request(1'b0, 7'd0, 24'h123456, 24'h654321, '0, '0));
    directed.push_back(make_request(1'b0, 7'd1, 24'hFFFFFF, 24'h000000, '0, '0));
    directed.push_back(make_request(1'b1, 7'd1, 24'h000000, 24'hABCDEF, '1, '1));
    directed.push_back(make_request(1'b0, 7'd2, 24'h000000, 24'hFFFFFF, '0, '0));
    directed.push_back(make_request(1'b0, 7'd64, 24'hFFFFFF, 24'h000000, '1, '1));
    directed.push_back(make_request(1'b0, 7'd65, 24'h0000FF, 24'hFF0000, '0, '0));
    directed.push_back(make_request(1'b1, 7'd127, 24'hFFFFFF, 24'h000000, 24'h000000,
                                    24'hFFFFFF));
    directed.push_back(make_request(1'b1, 7'd9, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                                    24'h000000));
    directed.push_back(make_request(1'b1, 7'd5, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                                    24'h000000));
    directed.push_back(make_request(1'b1, 7'd3, 24'h00FF00, 24'hFF00FF, 24'h00FF00,
                                    24'hFF00FF));
    directed.push_back(make_request(1'b0, 7'd16, 24'h808080, 24'h808080, '1, '1));
    directed.push_back(make_request(1'b1, 7'd0, '1, '1, '1, '1));
    foreach (directed[i]) send_request(directed[i], pick_gap());
    for (int i = 0; i < NumRandom; i++) begin
      // A stretch without sender gaps.
      send_request(random_request(), (i >= 40 && i < 60) ? 0 : pick_gap());
    end
    @(negedge clk_i);
    req.valid = 1'b0;
    sending_done = 1'b1;
  end

  // Receiver back-pressure, with one long hold-off to fill the block.
  initial begin
    int unsigned cycle_count;
    int unsigned gap;
    cycle_count = 0;
    pix.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cycle_count++;
      if (cycle_count == 1500) begin
        pix.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        cycle_count += HoldCycles;
        pix.ready = 1'b1;
      end else if (cycle_count > 3000 && cycle_count < 3600) begin
        pix.ready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        pix.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
        cycle_count += gap;
        pix.ready = 1'b1;
      end else begin
        pix.ready = 1'b1;
      end
    end
  end

  // Output check at each pixel transfer.
  always @(posedge clk_i) begin
    string msg;
    pixel_t got;
    if (rst_ni && pix.valid && pix.ready) begin
      got = '{blue: pix.blue, green: pix.green, red: pix.red, last: pix.last};
      msg = board.check_pixel(got);
      if (msg != "") report(msg);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (pix.valid && pix.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // End of run: drain, let the pipeline settle, then judge.
  initial begin
    wait (sending_done);
    while (board.owed_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (error_count == 0 && board.owed_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cgi_pkg.sv
src/cgi_if.sv
src/color_gradient_interpolator_core.sv
sim/testbench.sv
